// File: sv/arpr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the proxy ARP range responder.
package arpr_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned ApbAddrW      = 4;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned MatchW        = 6;

  localparam logic [15:0] HwEther    = 16'd1;
  localparam logic [15:0] HwIeee802  = 16'd6;
  localparam logic [15:0] ProtoIpv4  = 16'h0800;
  localparam logic [15:0] ArpRequest = 16'd1;
  localparam logic [15:0] ArpReply   = 16'd2;
  localparam logic [7:0]  Ipv4Len    = 8'd4;
  localparam logic [7:0]  LoopbackNet = 8'd127;
  localparam logic [3:0]  McastNet   = 4'hE;
  localparam logic [1:0]  ClassForUs = 2'd0;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } arpr_op_e;

  typedef enum logic [1:0] {
    REG_PROXY_ENABLE = 2'd0,
    REG_PORT_HW_TYPE = 2'd1,
    REG_HW_ADDR_LEN  = 2'd2,
    REG_UNUSED       = 2'd3
  } arpr_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } arpr_state_e;

  typedef struct packed {
    logic        proxy_enable;
    logic [15:0] port_hw_type;
    logic [5:0]  hw_addr_len;
  } arpr_cfg_t;

  typedef struct packed {
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [7:0]  range_port;
  } arpr_entry_t;

  typedef struct packed {
    logic              verdict;
    logic              reply_valid;
    logic [31:0]       reply_source_ip;
    logic [31:0]       reply_dest_ip;
    logic [47:0]       reply_dest_mac;
    logic [MatchW-1:0] matched_entry;
    logic              table_full;
  } arpr_res_t;

endpackage

// File: sv/arpr_req_if.sv
`timescale 1ns / 1ps
// Request channel: one operation per request.
interface arpr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [15:0] arp_op;
  logic [7:0]  hw_len;
  logic [7:0]  proto_len;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [7:0]  port_index;
  logic [1:0]  frame_class;
  logic        target_is_local;
  logic [47:0] sender_mac;

  modport source (
    output valid, opcode, hw_type, proto_type, arp_op, hw_len, proto_len,
           sender_ip, target_ip, port_index, frame_class, target_is_local, sender_mac,
    input  ready
  );
  modport sink (
    input  valid, opcode, hw_type, proto_type, arp_op, hw_len, proto_len,
           sender_ip, target_ip, port_index, frame_class, target_is_local, sender_mac,
    output ready
  );
endinterface

// File: sv/arpr_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one verdict per request.
interface arpr_rsp_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic        reply_valid;
  logic [31:0] reply_source_ip;
  logic [31:0] reply_dest_ip;
  logic [47:0] reply_dest_mac;
  logic [5:0]  matched_entry;
  logic        table_full;

  modport source (
    output valid, verdict, reply_valid, reply_source_ip, reply_dest_ip,
           reply_dest_mac, matched_entry, table_full,
    input  ready
  );
  modport sink (
    input  valid, verdict, reply_valid, reply_source_ip, reply_dest_ip,
           reply_dest_mac, matched_entry, table_full,
    output ready
  );
endinterface

// File: sv/arpr_regs.sv
`timescale 1ns / 1ps
// APB configuration registers of the proxy ARP range responder.
module arpr_regs
  import arpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output arpr_cfg_t           cfg_o
);

  arpr_cfg_t cfg_q, cfg_d;
  arpr_reg_e reg_idx;
  logic      wr_en;

  assign reg_idx = arpr_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_PROXY_ENABLE: cfg_d.proxy_enable = pwdata[0];
        REG_PORT_HW_TYPE: cfg_d.port_hw_type = pwdata[15:0];
        REG_HW_ADDR_LEN:  cfg_d.hw_addr_len  = pwdata[5:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROXY_ENABLE: prdata = {31'd0, cfg_q.proxy_enable};
      REG_PORT_HW_TYPE: prdata = {16'd0, cfg_q.port_hw_type};
      REG_HW_ADDR_LEN:  prdata = {26'd0, cfg_q.hw_addr_len};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.proxy_enable <= 1'b0;
      cfg_q.port_hw_type <= HwEther;
      cfg_q.hw_addr_len  <= 6'd6;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/arpr_mem.sv
`timescale 1ns / 1ps
// Range table memory: one write port, one registered read port.
module arpr_mem
  import arpr_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  arpr_entry_t      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output arpr_entry_t      rdata_o
);

  arpr_entry_t mem [TableDepth];
  arpr_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/arpr_ctrl.sv
`timescale 1ns / 1ps
// Request decode, header checks, table walk and result register.
module arpr_ctrl
  import arpr_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  parameter int unsigned CountW     = $clog2(TableDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arpr_cfg_t        cfg_i,
  arpr_req_if.sink         req_i,
  arpr_rsp_if.source       rsp_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output arpr_entry_t      mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  arpr_entry_t      mem_rdata_i
);

  arpr_state_e      state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] rd_idx_q, rd_idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic [AddrW-1:0] pend_idx_q, pend_idx_d;
  logic [31:0]      tip_q, tip_d, sip_q, sip_d;
  logic [7:0]       port_q, port_d;
  logic [47:0]      mac_q, mac_d;
  arpr_res_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  arpr_res_t        out_q, out_d;

  logic     accept, drop, types_ok, hdr_ok, scan_ok;
  logic     more, hit, issue, scan_end, out_free;
  arpr_op_e op;

  assign op       = arpr_op_e'(req_i.opcode);
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // Header checks of the incoming request
  always_comb begin
    drop = (req_i.hw_len != {2'd0, cfg_i.hw_addr_len}) ||
           (req_i.frame_class != ClassForUs) || (req_i.proto_len != Ipv4Len);
    if (cfg_i.port_hw_type == HwEther || cfg_i.port_hw_type == HwIeee802) begin
      types_ok = (req_i.hw_type == HwEther) || (req_i.hw_type == HwIeee802);
    end else begin
      types_ok = (req_i.hw_type == cfg_i.port_hw_type);
    end
    types_ok = types_ok && (req_i.proto_type == ProtoIpv4);
    hdr_ok = types_ok &&
             (req_i.arp_op == ArpRequest || req_i.arp_op == ArpReply) &&
             (req_i.target_ip[31:24] != LoopbackNet) &&
             (req_i.target_ip[31:28] != McastNet) &&
             (req_i.sender_ip != 32'd0);
    scan_ok = hdr_ok && (req_i.arp_op == ArpRequest) && cfg_i.proxy_enable &&
              !req_i.target_is_local;
  end

  // Compare the entry read in the previous cycle
  assign more     = (rd_idx_q < cnt_q);
  assign hit      = (state_q == ST_SCAN) && rd_pend_q &&
                    (mem_rdata_i.range_port != 8'd0) &&
                    (mem_rdata_i.range_port == port_q) &&
                    (mem_rdata_i.range_low <= tip_q) &&
                    (tip_q <= mem_rdata_i.range_high);
  assign issue    = (state_q == ST_SCAN) && more && !hit;
  assign scan_end = hit || !more;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_CHECK && !drop && scan_ok && cnt_q != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = rd_pend_q;
    pend_idx_d  = pend_idx_q;
    tip_d       = tip_q;
    sip_d       = sip_q;
    port_d      = port_q;
    mac_d       = mac_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_idx_q[AddrW-1:0];
    mem_waddr_o = cnt_q[AddrW-1:0];
    mem_wdata_o.range_low  = req_i.sender_ip;
    mem_wdata_o.range_high = req_i.target_ip;
    mem_wdata_o.range_port = req_i.port_index;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          tip_d     = req_i.target_ip;
          sip_d     = req_i.sender_ip;
          port_d    = req_i.port_index;
          mac_d     = req_i.sender_mac;
          res_d     = '0;
          rd_idx_d  = '0;
          rd_pend_d = 1'b0;
          case (op)
            OP_CHECK: res_d.verdict = drop;
            OP_ADD: begin
              if (cnt_q == CountW'(TableDepth)) begin
                res_d.table_full = 1'b1;
              end else begin
                mem_we_o = 1'b1;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            OP_CLEAR: cnt_d = '0;
            default:  res_d = '0;
          endcase
        end
      end
      ST_SCAN: begin
        mem_re_o   = issue;
        rd_pend_d  = issue;
        pend_idx_d = rd_idx_q[AddrW-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (hit) begin
          res_d.reply_valid     = 1'b1;
          res_d.reply_source_ip = tip_q;
          res_d.reply_dest_ip   = sip_q;
          res_d.reply_dest_mac  = mac_q;
          res_d.matched_entry   = MatchW'(pend_idx_q);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    tip_q      <= tip_d;
    sip_q      <= sip_d;
    port_q     <= port_d;
    mac_q      <= mac_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.verdict         = out_q.verdict;
  assign rsp_o.reply_valid     = out_q.reply_valid;
  assign rsp_o.reply_source_ip = out_q.reply_source_ip;
  assign rsp_o.reply_dest_ip   = out_q.reply_dest_ip;
  assign rsp_o.reply_dest_mac  = out_q.reply_dest_mac;
  assign rsp_o.matched_entry   = out_q.matched_entry;
  assign rsp_o.table_full      = out_q.table_full;

endmodule

// File: sv/arp_proxy_range_responder_unit.sv
`timescale 1ns / 1ps
// Proxy ARP range responder.
// A request on req_i carries one operation: check an ARP header, add a NAT
// range (start in sender_ip, end in target_ip, port in port_index) or clear
// the range table. Every request gives exactly one result on rsp_o: a
// drop/accept verdict, an optional proxy reply with the first matching range,
// or table_full for an add to a full table.
// Ranges live in a synchronous RAM with a registered read port. A check that
// qualifies for a reply walks the stored entries one per cycle, overlapping
// the read of the next entry with the compare of the current one, and stops
// at the first hit.
// Add, clear and non-walking checks register their result in res_q and then
// move it to the output register; a walking check first visits entries in
// ST_SCAN, up to the entry count. A new request is taken in the cycle after
// the result is loaded into the output register.
// A stalled receiver holds the result in the output register; the block
// then finishes the next request only up to its result and waits.
// Reset empties the table (entry count 0) and loads the register defaults;
// no clearing pass is needed. Configuration goes through the APB port.
module arp_proxy_range_responder_unit
  import arpr_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  arpr_req_if.sink            req_i,
  arpr_rsp_if.source          rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  arpr_cfg_t        cfg;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  arpr_entry_t      mem_wdata, mem_rdata;

  arpr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  arpr_mem #(
    .TableDepth (TableDepth),
    .AddrW      (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  arpr_ctrl #(
    .TableDepth (TableDepth),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

// File: sv/arpr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the proxy ARP range responder, bound to the top level.
module arpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        verdict,
  input logic        reply_valid,
  input logic [31:0] reply_source_ip,
  input logic [5:0]  matched_entry,
  input logic        table_full
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(reply_source_ip) && $stable(verdict))
    else $error("stalled result changed");

  // One request in flight: no request is taken right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one busy");

  // A reply excludes drop and table-full; no reply leaves the match index clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (reply_valid ? (!verdict && !table_full)
                               : (matched_entry == 6'd0 && reply_source_ip == 32'd0)))
    else $error("inconsistent result fields");

endmodule

bind arp_proxy_range_responder_unit arpr_checker u_arpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .verdict         (rsp_o.verdict),
  .reply_valid     (rsp_o.reply_valid),
  .reply_source_ip (rsp_o.reply_source_ip),
  .matched_entry   (rsp_o.matched_entry),
  .table_full      (rsp_o.table_full)
);
